// ===== design/stli_pkg.sv =====
// Shared types and codes for the sorted table linear interpolator.
package stli_pkg;

   localparam logic [1:0] MODE_LOAD   = 2'd0;
   localparam logic [1:0] MODE_QUERY  = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_FULL  = 3'd1;
   localparam logic [2:0] ST_FEW   = 3'd2;
   localparam logic [2:0] ST_ABOVE = 3'd3;
   localparam logic [2:0] ST_ZERO  = 3'd4;
   localparam logic [2:0] ST_SAT   = 3'd5;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [15:0] key;
      logic signed [15:0] value;
   } req_type;

   typedef struct packed {
      logic signed [15:0] result_value;
      logic [2:0]         status;
      logic [6:0]         entry_count;
   } rsp_type;

endpackage

// ===== design/stli_ram.sv =====
// Generic single-port RAM with registered read.
module stli_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write or read one entry per cycle
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[addr] <= wr_data;
      rd_data <= mem_ff[addr];
   end
endmodule

// ===== design/stli_front.sv =====
// Front end: request queue between the input port and the table engine.
module stli_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  stli_pkg::req_type req_data,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output stli_pkg::req_type cmd_data
);
   import stli_pkg::*;

   req_type    q_ff [2];
   req_type    q_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign req_ready = (cnt_ff != 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_data  = q_ff[0];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   // Shift the two-entry queue
   always_comb begin
      q_in   = q_ff;
      cnt_in = cnt_ff;
      if (pop) begin
         q_in[0] = q_ff[1];
         cnt_in  = cnt_in - 2'd1;
      end
      if (push) begin
         q_in[cnt_in[0]] = req_data;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) cnt_ff <= '0;
      else       cnt_ff <= cnt_in;
   end
endmodule

// ===== design/stli_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module stli_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [32:0] dividend,
   input  logic [16:0] divisor,
   output logic        done,
   output logic [32:0] quotient
);
   logic [32:0] quo_ff, quo_in;
   logic [16:0] rem_ff, rem_in;
   logic [16:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [17:0] trial;

   assign quotient = quo_ff;
   assign done     = busy_ff && (cnt_ff == 6'd0);
   assign trial    = {rem_ff, quo_ff[32]};

   // Shift in one dividend bit, subtract when it fits
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = 6'd33;
         busy_in = 1'b1;
      end else if (busy_ff && cnt_ff != 6'd0) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = 17'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[31:0], 1'b1};
         end else begin
            rem_in = trial[16:0];
            quo_in = {quo_ff[31:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
      end else if (done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end
endmodule

// ===== design/stli_engine.sv =====
// Back end: table walk, insertion shift, interpolation and result register.
module stli_engine #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  stli_pkg::req_type cmd_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output stli_pkg::rsp_type rsp_data
);
   import stli_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_LSCAN = 4'd1;
   localparam logic [3:0] S_LRD   = 4'd2;
   localparam logic [3:0] S_LWR   = 4'd3;
   localparam logic [3:0] S_QSCAN = 4'd4;
   localparam logic [3:0] S_QLO   = 4'd5;
   localparam logic [3:0] S_QMUL  = 4'd6;
   localparam logic [3:0] S_QDIV  = 4'd7;
   localparam logic [3:0] S_QDONE = 4'd8;
   localparam logic [3:0] S_OUT   = 4'd9;
   localparam logic [3:0] S_QHI   = 4'd10;

   logic [3:0]          st_ff, st_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       idx_ff, idx_in;
   req_type             cur_ff, cur_in;
   rsp_type             out_ff, out_in;
   logic                out_v_ff, out_v_in;
   logic                above_ff, above_in;
   logic signed [15:0]  k1_ff, k1_in, v1_ff, v1_in, k0_ff, k0_in, v0_ff, v0_in;
   logic signed [16:0]  dk_ff, dk_in;
   logic signed [33:0]  num_ff, num_in;
   logic                neg_ff, neg_in;
   logic                rd_wait_ff, rd_wait_in;

   logic                ram_we;
   logic [AW-1:0]       ram_addr;
   logic [15:0]         ram_kw, ram_vw, ram_kr, ram_vr;
   logic                div_start, div_done;
   logic [32:0]         div_dvd, div_quo;
   logic signed [34:0]  res;
   logic [CW-1:0]       count_p1;
   logic [6:0]          cnt7;

   stli_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_key_ram (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr), .wr_data(ram_kw), .rd_data(ram_kr));
   stli_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_val_ram (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr), .wr_data(ram_vw), .rd_data(ram_vr));

   stli_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_dvd),
      .divisor(dk_ff), .done(div_done), .quotient(div_quo));

   assign cmd_ready = (st_ff == S_IDLE) && !out_v_ff;
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;
   assign count_p1  = count_ff + CW'(1);
   // magnitude of the product plus half the divisor, for round to nearest
   assign div_dvd   = 33'(num_ff[33] ? -num_ff : num_ff) + 33'(dk_ff[16:1]);
   assign res       = 35'(v0_ff) + (neg_ff ? -35'(div_quo) : 35'(div_quo));

   // Walk the table, one entry per cycle on query; loads shift entries up
   always_comb begin
      st_in      = st_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      cur_in     = cur_ff;
      out_in     = out_ff;
      out_v_in   = out_v_ff;
      above_in   = above_ff;
      k0_in = k0_ff; k1_in = k1_ff; v0_in = v0_ff; v1_in = v1_ff;
      dk_in      = dk_ff;
      num_in     = num_ff;
      neg_in     = neg_ff;
      rd_wait_in = 1'b0;
      ram_we     = 1'b0;
      ram_addr   = idx_ff[AW-1:0];
      ram_kw     = cur_ff.key;
      ram_vw     = cur_ff.value;
      div_start  = 1'b0;
      cnt7       = 7'(count_ff);
      if (out_v_ff && rsp_ready) out_v_in = 1'b0;
      case (st_ff)
         S_IDLE: begin
            if (cmd_valid && cmd_ready) begin
               cur_in = cmd_data;
               out_in = '{result_value: '0, status: ST_OK, entry_count: cnt7};
               case (cmd_data.mode)
                  MODE_LOAD: begin
                     if (count_ff >= CW'(TABLE_DEPTH)) begin
                        out_in.status = ST_FULL;
                        st_in = S_OUT;
                     end else begin
                        // scan down from the top to find the insertion point
                        idx_in = count_ff;
                        st_in  = S_LSCAN;
                     end
                  end
                  MODE_QUERY: begin
                     if (count_ff < CW'(2)) begin
                        out_in.status = ST_FEW;
                        st_in = S_OUT;
                     end else begin
                        idx_in = CW'(1);
                        rd_wait_in = 1'b1;
                        ram_addr = AW'(1);
                        st_in = S_QSCAN;
                     end
                  end
                  MODE_CLEAR: begin
                     count_in = '0;
                     out_in.entry_count = '0;
                     st_in = S_OUT;
                  end
                  default: st_in = S_OUT;
               endcase
            end
         end
         S_LSCAN: begin
            // idx is the candidate slot; look at entry idx-1
            if (idx_ff == '0) st_in = S_LWR;
            else begin
               ram_addr = AW'(idx_ff - CW'(1));
               st_in = S_LRD;
            end
         end
         S_LRD: begin
            ram_addr = AW'(idx_ff - CW'(1));
            if ($signed(ram_kr) <= cur_ff.key) st_in = S_LWR;
            else begin
               ram_we   = 1'b1;
               ram_addr = idx_ff[AW-1:0];
               ram_kw   = ram_kr;
               ram_vw   = ram_vr;
               idx_in   = idx_ff - CW'(1);
               st_in    = S_LSCAN;
            end
         end
         S_LWR: begin
            ram_we   = 1'b1;
            count_in = count_p1;
            out_in.entry_count = 7'(count_p1);
            st_in    = S_OUT;
         end
         S_QSCAN: begin
            if (!rd_wait_ff) begin
               ram_addr = idx_ff[AW-1:0];
               rd_wait_in = 1'b1;
            end else if (cur_ff.key > $signed(ram_kr) && idx_ff != count_ff - CW'(1)) begin
               idx_in = idx_ff + CW'(1);
               ram_addr = AW'(idx_ff + CW'(1));
               rd_wait_in = 1'b1;
            end else begin
               above_in = cur_ff.key > $signed(ram_kr);
               k1_in = ram_kr;
               v1_in = ram_vr;
               ram_addr = AW'(idx_ff - CW'(1));
               st_in = S_QHI;
            end
         end
         S_QHI: begin
            ram_addr = AW'(idx_ff - CW'(1));
            st_in = S_QLO;
         end
         S_QLO: begin
            k0_in = ram_kr;
            v0_in = ram_vr;
            dk_in = 17'(k1_ff) - 17'($signed(ram_kr));
            st_in = S_QMUL;
         end
         S_QMUL: begin
            if (dk_ff == '0) begin
               out_in.result_value = v0_ff;
               out_in.status = ST_ZERO;
               st_in = S_OUT;
            end else begin
               num_in = 34'(17'(cur_ff.key) - 17'(k0_ff)) * 34'(17'(v1_ff) - 17'(v0_ff));
               neg_in = 1'b0;
               st_in = S_QDIV;
            end
         end
         S_QDIV: begin
            // keep the sign, divide the rounded magnitude
            neg_in = num_ff[33];
            div_start = 1'b1;
            st_in = S_QDONE;
         end
         S_QDONE: begin
            if (div_done) begin
               out_in.status = above_ff ? ST_ABOVE : ST_OK;
               if (res > 35'sd32767) begin
                  out_in.result_value = 16'sh7fff;
                  if (!above_ff) out_in.status = ST_SAT;
               end else if (res < -35'sd32768) begin
                  out_in.result_value = 16'sh8000;
                  if (!above_ff) out_in.status = ST_SAT;
               end else out_in.result_value = res[15:0];
               st_in = S_OUT;
            end
         end
         S_OUT: begin
            out_v_in = 1'b1;
            st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in; out_ff <= out_in; idx_ff <= idx_in;
      above_ff <= above_in; k0_ff <= k0_in; k1_ff <= k1_in;
      v0_ff <= v0_in; v1_ff <= v1_in; dk_ff <= dk_in;
      num_ff <= num_in; neg_ff <= neg_in; rd_wait_ff <= rd_wait_in;
      if (reset) begin
         st_ff    <= S_IDLE;
         count_ff <= '0;
         out_v_ff <= 1'b0;
      end else begin
         st_ff    <= st_in;
         count_ff <= count_in;
         out_v_ff <= out_v_in;
      end
   end
endmodule

// ===== design/sorted_table_linear_interpolator.sv =====
// Top level: sorted breakpoint table with linear interpolation lookup.
// A load scans down from the top, shifting each entry above the new key up a slot;
// a query walks the stored keys in turn, then runs the 33-step divider; clear and
// rejected requests respond without touching the table.
// One request is handled at a time; the next is taken once the response is accepted.
// Synchronous reset empties the table and the queue; table RAM is not cleared.
module sorted_table_linear_interpolator #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  stli_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output stli_pkg::rsp_type rsp_data
);
   import stli_pkg::*;

   logic    cmd_valid, cmd_ready;
   req_type cmd_data;

   stli_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_data(req_data), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
      .cmd_data(cmd_data));

   stli_engine #(.TABLE_DEPTH(TABLE_DEPTH)) u_engine (
      .clock(clock), .reset(reset), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
      .cmd_data(cmd_data), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_data(rsp_data));
endmodule
